### sv/vfv_pkg.sv
// Package with the shared types, codes and default sizes of the voxel face visibility unit.
package vfv_pkg;

    localparam int CHUNK_WIDTH_DEF = 16;
    localparam int CHUNK_TALL_DEF  = 32;
    localparam int SLOT_COUNT_DEF  = 16;
    localparam int COORD_BITS_DEF  = 16;

    localparam int ACTION_W   = 2;
    localparam int SLOT_W     = 4;
    localparam int TAG_W      = 12;
    localparam int POS_Y_W    = 7;
    localparam int MASK_W     = 6;
    localparam int STATUS_W   = 2;
    localparam int OUT_DATA_W = 8;
    localparam int FACE_W     = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD,
        ACT_UNLOAD,
        ACT_WRITE,
        ACT_QUERY
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK,
        STAT_NO_CHUNK,
        STAT_HEIGHT
    } status_t;

    localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
    localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd1;
    localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd2;
    localparam logic [FACE_W-1:0] FACE_BACK   = 3'd3;
    localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd4;
    localparam logic [FACE_W-1:0] FACE_TOP    = 3'd5;

    typedef struct packed {
        logic signed [1:0] dx;
        logic signed [1:0] dy;
        logic signed [1:0] dz;
    } face_step_t;

    function automatic face_step_t face_step(input logic [FACE_W-1:0] face);
        face_step_t step;
        step = '0;
        case (face)
            FACE_FRONT:  step.dz = 2'sd1;
            FACE_RIGHT:  step.dx = 2'sd1;
            FACE_LEFT:   step.dx = -2'sd1;
            FACE_BACK:   step.dz = -2'sd1;
            FACE_BOTTOM: step.dy = -2'sd1;
            FACE_TOP:    step.dy = 2'sd1;
            default:     step = '0;
        endcase
        return step;
    endfunction

endpackage

### sv/voxel_face_visibility_unit.sv
// Top level of the voxel face visibility unit: slot table, occupancy memory and face sequencer.
//
// Input items arrive on the s_axis channel; the action code travels in tuser and the
// slot, chunk tag, position and solid bit in tdata. Each transaction on s_axis gives
// exactly one result transaction on m_axis, with the face mask and status in tdata.
// Load and unload update the slot table and pass straight on to the result state.
// A voxel write looks up its chunk, reads the occupancy row and writes it back. A
// query steps through the six neighbor faces, one occupancy read per face on the
// single memory port, through a three-stage lookup pipeline.
// One item is worked on at a time; the next is accepted as soon as the
// previous result sits in the output register, even if the receiver has not taken it.
// When the receiver stalls, a finished result waits until the output register frees.
// After reset the occupancy memory is cleared one row per cycle, all SLOT_COUNT *
// CHUNK_WIDTH * CHUNK_TALL rows (8192 with the defaults); s_axis_tready stays low
// during that pass. CHUNK_WIDTH must be a power of two.
module voxel_face_visibility_unit #(
    parameter int CHUNK_WIDTH = vfv_pkg::CHUNK_WIDTH_DEF,
    parameter int CHUNK_TALL  = vfv_pkg::CHUNK_TALL_DEF,
    parameter int SLOT_COUNT  = vfv_pkg::SLOT_COUNT_DEF,
    parameter int COORD_BITS  = vfv_pkg::COORD_BITS_DEF,
    localparam int IN_DATA_W  = ((vfv_pkg::SLOT_W + 2 * vfv_pkg::TAG_W + 2 * COORD_BITS
                                  + vfv_pkg::POS_Y_W + 1 + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0 up: slot, chunk_x, chunk_z, pos_x, pos_y, pos_z, solid, zero padding.
    input  logic [IN_DATA_W-1:0]              s_axis_tdata,
    // Fields from bit 0 up: action.
    input  logic [vfv_pkg::ACTION_W-1:0]      s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0 up: face_mask, status.
    output logic [vfv_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import vfv_pkg::*;

    localparam int CB      = COORD_BITS;
    localparam int NB      = COORD_BITS + 1;
    localparam int CMP_W   = (NB > TAG_W) ? NB : TAG_W;
    localparam int CWB     = $clog2(CHUNK_WIDTH);
    localparam int LYW     = $clog2(CHUNK_TALL);
    localparam int SW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ROWS    = SLOT_COUNT * CHUNK_WIDTH * CHUNK_TALL;
    localparam int AW      = $clog2(ROWS);
    localparam int OFF_CX  = SLOT_W;
    localparam int OFF_CZ  = OFF_CX + TAG_W;
    localparam int OFF_PX  = OFF_CZ + TAG_W;
    localparam int OFF_PY  = OFF_PX + CB;
    localparam int OFF_PZ  = OFF_PY + POS_Y_W;
    localparam int OFF_SOL = OFF_PZ + CB;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    state_t                   state_reg;
    logic [AW-1:0]            clr_cnt_reg;
    action_t                  act_reg;
    logic signed [CB-1:0]     px_reg;
    logic signed [POS_Y_W-1:0] py_reg;
    logic signed [CB-1:0]     pz_reg;
    logic                     solid_reg;
    logic [FACE_W-1:0]        face_cnt_reg;
    logic [FACE_W-1:0]        last_face_reg;

    logic                     slot_valid_reg [SLOT_COUNT];
    logic signed [TAG_W-1:0]  slot_cx_reg    [SLOT_COUNT];
    logic signed [TAG_W-1:0]  slot_cz_reg    [SLOT_COUNT];

    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic [FACE_W-1:0]        s1_face_reg;
    logic signed [NB-1:0]     s1_x_reg;
    logic signed [POS_Y_W:0]  s1_y_reg;
    logic signed [NB-1:0]     s1_z_reg;
    logic signed [NB-1:0]     s1_x_next;
    logic signed [POS_Y_W:0]  s1_y_next;
    logic signed [NB-1:0]     s1_z_next;
    face_step_t               step;

    logic                     s2_valid_reg;
    logic                     s2_last_reg;
    logic [FACE_W-1:0]        s2_face_reg;
    status_t                  s2_status_reg;
    logic [SW-1:0]            s2_slot_reg;
    logic [CWB-1:0]           s2_lx_reg;
    logic [LYW-1:0]           s2_ly_reg;
    logic [CWB-1:0]           s2_lz_reg;
    status_t                  s2_status_next;
    logic [SW-1:0]            hit_idx;
    logic                     hit;
    logic                     y_ok;
    logic signed [CMP_W-1:0]  x_wide;
    logic signed [CMP_W-1:0]  z_wide;
    logic signed [CMP_W-1:0]  cx;
    logic signed [CMP_W-1:0]  cz;
    logic [AW-1:0]            s2_addr;

    logic                     s3_valid_reg;
    logic                     s3_last_reg;
    logic [FACE_W-1:0]        s3_face_reg;
    status_t                  s3_status_reg;
    logic [CWB-1:0]           s3_lz_reg;
    logic [AW-1:0]            s3_addr_reg;

    logic [MASK_W-1:0]        mask_reg;
    status_t                  res_status_reg;
    logic                     out_valid_reg;
    logic [MASK_W-1:0]        out_mask_reg;
    status_t                  out_status_reg;

    logic [CHUNK_WIDTH-1:0]   occ_mem [ROWS];
    logic [CHUNK_WIDTH-1:0]   mem_rdata_reg;
    logic [CHUNK_WIDTH-1:0]   wb_data;
    logic [CHUNK_WIDTH-1:0]   mem_wdata;
    logic [AW-1:0]            mem_addr;
    logic                     mem_we;
    logic                     wb_en;
    logic                     clearing;
    logic                     in_accept;
    logic [SW-1:0]            in_slot_idx;
    logic                     in_slot_ok;
    action_t                  in_action;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_action     = action_t'(s_axis_tuser);
    assign in_slot_idx   = SW'(s_axis_tdata[SLOT_W-1:0]);
    assign in_slot_ok    = (int'(s_axis_tdata[SLOT_W-1:0]) < SLOT_COUNT);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_status_reg, out_mask_reg};

    always_comb
    begin
        step = (act_reg == ACT_QUERY) ? face_step(face_cnt_reg) : '0;
        s1_x_next = NB'(px_reg) + NB'(step.dx);
        s1_y_next = (POS_Y_W + 1)'(py_reg) + (POS_Y_W + 1)'(step.dy);
        s1_z_next = NB'(pz_reg) + NB'(step.dz);
    end

    always_comb
    begin
        x_wide  = CMP_W'(s1_x_reg);
        z_wide  = CMP_W'(s1_z_reg);
        cx      = x_wide >>> CWB;
        cz      = z_wide >>> CWB;
        hit     = 1'b0;
        hit_idx = '0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--)
        begin
            if (slot_valid_reg[s] && CMP_W'(slot_cx_reg[s]) == cx
                && CMP_W'(slot_cz_reg[s]) == cz)
            begin
                hit     = 1'b1;
                hit_idx = SW'(s);
            end
        end
        y_ok = !s1_y_reg[POS_Y_W] && (int'(s1_y_reg) < CHUNK_TALL);
        if (!hit)
        begin
            s2_status_next = STAT_NO_CHUNK;
        end
        else if (!y_ok)
        begin
            s2_status_next = STAT_HEIGHT;
        end
        else
        begin
            s2_status_next = STAT_OK;
        end
    end

    assign s2_addr = AW'(AW'({s2_slot_reg, s2_lx_reg}) * AW'(CHUNK_TALL)) + AW'(s2_ly_reg);

    always_comb
    begin
        wb_data = mem_rdata_reg;
        wb_data[s3_lz_reg] = solid_reg;
    end

    assign clearing  = (state_reg == ST_CLEAR);
    assign wb_en     = s3_valid_reg && (act_reg == ACT_WRITE) && (s3_status_reg == STAT_OK);
    assign mem_we    = clearing || wb_en;
    assign mem_addr  = clearing ? clr_cnt_reg : (wb_en ? s3_addr_reg : s2_addr);
    assign mem_wdata = clearing ? '0 : wb_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            occ_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= occ_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            act_reg        <= ACT_LOAD;
            px_reg         <= '0;
            py_reg         <= '0;
            pz_reg         <= '0;
            solid_reg      <= 1'b0;
            face_cnt_reg   <= '0;
            last_face_reg  <= '0;
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                slot_valid_reg[s] <= 1'b0;
                slot_cx_reg[s]    <= '0;
                slot_cz_reg[s]    <= '0;
            end
            s1_valid_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            s1_face_reg    <= '0;
            s1_x_reg       <= '0;
            s1_y_reg       <= '0;
            s1_z_reg       <= '0;
            s2_valid_reg   <= 1'b0;
            s2_last_reg    <= 1'b0;
            s2_face_reg    <= '0;
            s2_status_reg  <= STAT_OK;
            s2_slot_reg    <= '0;
            s2_lx_reg      <= '0;
            s2_ly_reg      <= '0;
            s2_lz_reg      <= '0;
            s3_valid_reg   <= 1'b0;
            s3_last_reg    <= 1'b0;
            s3_face_reg    <= '0;
            s3_status_reg  <= STAT_OK;
            s3_lz_reg      <= '0;
            s3_addr_reg    <= '0;
            mask_reg       <= '0;
            res_status_reg <= STAT_OK;
            out_valid_reg  <= 1'b0;
            out_mask_reg   <= '0;
            out_status_reg <= STAT_OK;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready && state_reg != ST_RESULT)
            begin
                out_valid_reg <= 1'b0;
            end

            s1_valid_reg <= (state_reg == ST_ISSUE);
            s1_last_reg  <= (state_reg == ST_ISSUE) && (face_cnt_reg == last_face_reg);
            s1_face_reg  <= face_cnt_reg;
            s1_x_reg     <= s1_x_next;
            s1_y_reg     <= s1_y_next;
            s1_z_reg     <= s1_z_next;

            s2_valid_reg  <= s1_valid_reg;
            s2_last_reg   <= s1_last_reg;
            s2_face_reg   <= s1_face_reg;
            s2_status_reg <= s2_status_next;
            s2_slot_reg   <= hit_idx;
            s2_lx_reg     <= s1_x_reg[CWB-1:0];
            s2_ly_reg     <= s1_y_reg[LYW-1:0];
            s2_lz_reg     <= s1_z_reg[CWB-1:0];

            s3_valid_reg  <= s2_valid_reg;
            s3_last_reg   <= s2_last_reg;
            s3_face_reg   <= s2_face_reg;
            s3_status_reg <= s2_status_reg;
            s3_lz_reg     <= s2_lz_reg;
            s3_addr_reg   <= s2_addr;

            if (s3_valid_reg)
            begin
                mask_reg[s3_face_reg] <= !((s3_status_reg == STAT_OK)
                                           && mem_rdata_reg[s3_lz_reg]);
                res_status_reg <= s3_status_reg;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(ROWS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        act_reg       <= in_action;
                        px_reg        <= s_axis_tdata[OFF_PX +: CB];
                        py_reg        <= s_axis_tdata[OFF_PY +: POS_Y_W];
                        pz_reg        <= s_axis_tdata[OFF_PZ +: CB];
                        solid_reg     <= s_axis_tdata[OFF_SOL];
                        face_cnt_reg  <= FACE_FRONT;
                        last_face_reg <= (in_action == ACT_QUERY) ? FACE_TOP : FACE_FRONT;
                        mask_reg      <= '0;
                        res_status_reg <= STAT_OK;
                        case (in_action)
                            ACT_LOAD:
                            begin
                                if (in_slot_ok)
                                begin
                                    slot_valid_reg[in_slot_idx] <= 1'b1;
                                    slot_cx_reg[in_slot_idx] <= s_axis_tdata[OFF_CX +: TAG_W];
                                    slot_cz_reg[in_slot_idx] <= s_axis_tdata[OFF_CZ +: TAG_W];
                                end
                                state_reg <= ST_RESULT;
                            end
                            ACT_UNLOAD:
                            begin
                                if (in_slot_ok)
                                begin
                                    slot_valid_reg[in_slot_idx] <= 1'b0;
                                end
                                state_reg <= ST_RESULT;
                            end
                            default:
                            begin
                                state_reg <= ST_ISSUE;
                            end
                        endcase
                    end
                end
                ST_ISSUE:
                begin
                    face_cnt_reg <= face_cnt_reg + 1'b1;
                    if (face_cnt_reg == last_face_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (s3_valid_reg && s3_last_reg)
                    begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_mask_reg   <= (act_reg == ACT_QUERY) ? mask_reg : '0;
                        out_status_reg <= (act_reg == ACT_WRITE) ? res_status_reg : STAT_OK;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_wb_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        wb_en |-> !s2_valid_reg)
        else $error("Write-back collides with a lookup read on the memory port.");

    a_faces_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_last_reg) |=> s1_valid_reg)
        else $error("Face sequence has a gap before its last face.");

    a_s3_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (state_reg == ST_ISSUE || state_reg == ST_DRAIN))
        else $error("Lookup data returned outside the issue or drain phase.");

    a_fault_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != STAT_OK) |-> (out_mask_reg == '0))
        else $error("Result carries both a fault status and a face mask.");

endmodule

### sim/tb.sv
// Self-checking stream testbench for the voxel face visibility unit with a mirrored chunk world.
`timescale 1ns / 1ps

import vfv_pkg::*;

localparam int ITEM_W = ((SLOT_W + 2 * TAG_W + 2 * COORD_BITS_DEF + POS_Y_W + 1 + 7) / 8) * 8;
localparam int ROW_TOTAL = SLOT_COUNT_DEF * CHUNK_WIDTH_DEF * CHUNK_TALL_DEF;
localparam int FACE_DX[6] = '{0, 1, -1, 0, 0, 0};
localparam int FACE_DY[6] = '{0, 0, 0, 0, -1, 1};
localparam int FACE_DZ[6] = '{1, 0, 0, -1, 0, 0};

typedef struct packed {
    logic [ITEM_W-69:0]          pad;
    logic                        solid;
    logic signed [15:0]          pos_z;
    logic signed [POS_Y_W-1:0]   pos_y;
    logic signed [15:0]          pos_x;
    logic signed [TAG_W-1:0]     chunk_z;
    logic signed [TAG_W-1:0]     chunk_x;
    logic [SLOT_W-1:0]           slot;
} voxel_item_t;

typedef struct {
    logic [MASK_W-1:0] mask;
    status_t           status;
} face_result_t;

class voxel_world;
    bit                         loaded[SLOT_COUNT_DEF];
    int                         tag_x[SLOT_COUNT_DEF];
    int                         tag_z[SLOT_COUNT_DEF];
    logic [CHUNK_WIDTH_DEF-1:0] rows[ROW_TOTAL];
    face_result_t               awaited[$];
    int n_load, n_unload, n_write, n_write_refused, n_query, n_hidden;
    int n_checked, n_errors;

    function new();
        foreach (loaded[i])
        begin
            loaded[i] = 1'b0;
            tag_x[i]  = 0;
            tag_z[i]  = 0;
        end
        foreach (rows[i])
            rows[i] = '0;
    endfunction

    function int floor_chunk(input int v);
        int q;
        q = v / CHUNK_WIDTH_DEF;
        if (v % CHUNK_WIDTH_DEF != 0 && v < 0)
            q--;
        return q;
    endfunction

    // The lowest slot that carries the tag owns the voxel.
    function status_t locate(input int x, input int y, input int z,
                             output int row, output int zbit);
        int cx, cz, s;
        cx   = floor_chunk(x);
        cz   = floor_chunk(z);
        s    = -1;
        row  = 0;
        zbit = 0;
        for (int i = SLOT_COUNT_DEF - 1; i >= 0; i--)
            if (loaded[i] && tag_x[i] == cx && tag_z[i] == cz)
                s = i;
        if (s < 0)
            return STAT_NO_CHUNK;
        if (y < 0 || y >= CHUNK_TALL_DEF)
            return STAT_HEIGHT;
        row  = (s * CHUNK_WIDTH_DEF + x - cx * CHUNK_WIDTH_DEF) * CHUNK_TALL_DEF + y;
        zbit = z - cz * CHUNK_WIDTH_DEF;
        return STAT_OK;
    endfunction

    function void note_item(input action_t act, input voxel_item_t it);
        int px, py, pz, row, zbit;
        status_t st;
        face_result_t res;
        px = it.pos_x;
        py = it.pos_y;
        pz = it.pos_z;
        res.mask   = '0;
        res.status = STAT_OK;
        case (act)
            ACT_LOAD:
            begin
                n_load++;
                loaded[it.slot] = 1'b1;
                tag_x[it.slot]  = it.chunk_x;
                tag_z[it.slot]  = it.chunk_z;
            end
            ACT_UNLOAD:
            begin
                n_unload++;
                loaded[it.slot] = 1'b0;
            end
            ACT_WRITE:
            begin
                n_write++;
                res.status = locate(px, py, pz, row, zbit);
                if (res.status == STAT_OK)
                    rows[row][zbit] = it.solid;
                else
                    n_write_refused++;
            end
            default:
            begin
                n_query++;
                for (int f = 0; f < 6; f++)
                begin
                    st = locate(px + FACE_DX[f], py + FACE_DY[f], pz + FACE_DZ[f], row, zbit);
                    if (!(st == STAT_OK && rows[row][zbit] == 1'b1))
                        res.mask[f] = 1'b1;
                end
                if (res.mask != '1)
                    n_hidden++;
            end
        endcase
        awaited.insert(awaited.size(), res);
    endfunction

    function void check_result(input logic [OUT_DATA_W-1:0] data);
        face_result_t want;
        logic [MASK_W-1:0] got_mask;
        logic [STATUS_W-1:0] got_status;
        got_mask   = data[MASK_W-1:0];
        got_status = data[MASK_W+STATUS_W-1:MASK_W];
        n_checked++;
        if (awaited.size() == 0)
        begin
            n_errors++;
            if (n_errors <= 10)
                $display("Unexpected result: face_mask %02h status %0d", got_mask, got_status);
            return;
        end
        want = awaited.pop_front();
        if (got_mask !== want.mask || got_status !== want.status)
        begin
            n_errors++;
            if (n_errors <= 10)
                $display("Mismatch %0d: face_mask exp %02h got %02h, status exp %0d got %0d",
                         n_checked, want.mask, got_mask, want.status, got_status);
        end
    endfunction
endclass

module tb;

    localparam int RANDOM_ITEMS = 1625;
    localparam int QUIET_ITEMS  = 200;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [ITEM_W-1:0]     s_axis_tdata;
    logic [ACTION_W-1:0]   s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    voxel_world world = new();
    int cycle_count = 0;
    bit quiet = 1'b0;
    bit hold_now = 1'b0;
    bit tx_calm = 1'b0;
    int sent_x[SLOT_COUNT_DEF];
    int sent_z[SLOT_COUNT_DEF];
    int hub_x, hub_z;

    voxel_face_visibility_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, world.awaited.size());
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            world.check_result(m_axis_tdata);
    end

    initial
    begin : ready_gen
        int stall_left;
        bit rx_calm;
        stall_left = 0;
        rx_calm    = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 149) == 0)
                rx_calm = !rx_calm;
            if (hold_now)
            begin
                stall_left = HOLD_CYCLES;
                hold_now   = 1'b0;
            end
            else if (stall_left == 0 && !quiet && !rx_calm && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 12);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(input action_t act, input voxel_item_t it);
        if (!quiet && !tx_calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it;
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        world.note_item(act, it);
        if (act == ACT_LOAD)
        begin
            sent_x[it.slot] = it.chunk_x;
            sent_z[it.slot] = it.chunk_z;
        end
    endtask

    task automatic slot_op(input action_t act, input int s, input int cx, input int cz);
        voxel_item_t it;
        it         = '0;
        it.slot    = SLOT_W'(s);
        it.chunk_x = TAG_W'(cx);
        it.chunk_z = TAG_W'(cz);
        send_item(act, it);
    endtask

    task automatic voxel_op(input action_t act, input int x, input int y, input int z,
                            input bit solid);
        voxel_item_t it;
        it       = '0;
        it.pos_x = 16'(x);
        it.pos_y = POS_Y_W'(y);
        it.pos_z = 16'(z);
        it.solid = solid;
        send_item(act, it);
    endtask

    // Offsets cluster in a small window so that writes and queries meet.
    function automatic int pick_offset(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom_range(span / 2 - 2, span / 2 + 1);
        if (r < 6)
        begin
            case ($urandom_range(0, 3))
                0: return -1;
                1: return 0;
                2: return span - 1;
                default: return span;
            endcase
        end
        return $urandom_range(0, span - 1);
    endfunction

    function automatic int pick_tag(input int hub);
        int t;
        t = $urandom_range(0, 19);
        if (t == 0)
            return ($urandom_range(0, 1) == 1) ? 2047 : -2048;
        if (t == 1)
            return $urandom_range(0, 4095) - 2048;
        return hub + $urandom_range(0, 2);
    endfunction

    task automatic random_item();
        action_t act;
        voxel_item_t it;
        int r, s;
        it = '0;
        r  = $urandom_range(0, 99);
        if (r < 12)
        begin
            act        = action_t'($urandom_range(0, 3));
            it.slot    = SLOT_W'($urandom);
            it.chunk_x = TAG_W'($urandom);
            it.chunk_z = TAG_W'($urandom);
            it.pos_x   = 16'($urandom);
            it.pos_y   = POS_Y_W'($urandom);
            it.pos_z   = 16'($urandom);
            it.solid   = 1'($urandom);
        end
        else
        begin
            if (r < 22)
                act = ACT_LOAD;
            else if (r < 27)
                act = ACT_UNLOAD;
            else if (r < 62)
                act = ACT_WRITE;
            else
                act = ACT_QUERY;
            it.slot    = SLOT_W'($urandom_range(0, SLOT_COUNT_DEF - 1));
            it.chunk_x = TAG_W'(pick_tag(hub_x));
            it.chunk_z = TAG_W'(pick_tag(hub_z));
            s          = $urandom_range(0, SLOT_COUNT_DEF - 1);
            it.pos_x   = 16'(sent_x[s] * CHUNK_WIDTH_DEF + pick_offset(CHUNK_WIDTH_DEF));
            it.pos_z   = 16'(sent_z[s] * CHUNK_WIDTH_DEF + pick_offset(CHUNK_WIDTH_DEF));
            if ($urandom_range(0, 9) == 0)
                it.pos_y = POS_Y_W'($urandom);
            else
                it.pos_y = POS_Y_W'(pick_offset(CHUNK_TALL_DEF));
            it.solid = ($urandom_range(0, 9) < 6);
        end
        send_item(act, it);
    endtask

    initial
    begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_LOAD;
        foreach (sent_x[i])
        begin
            sent_x[i] = 0;
            sent_z[i] = 0;
        end
        hub_x = $urandom_range(0, 4093) - 2048;
        hub_z = $urandom_range(0, 4093) - 2048;
        @(posedge rst_n);
        @(posedge clk);

        // With nothing loaded every neighbor is air, and a write fails on the chunk first.
        voxel_op(ACT_QUERY, 0, 0, 0, 1'b0);
        voxel_op(ACT_WRITE, 5, -64, 5, 1'b1);
        slot_op(ACT_LOAD, 0, 0, 0);
        slot_op(ACT_LOAD, 1, -1, 0);
        voxel_op(ACT_WRITE, 0, 0, 0, 1'b1);
        voxel_op(ACT_WRITE, -1, 0, 0, 1'b1);
        voxel_op(ACT_WRITE, 0, 1, 0, 1'b1);
        voxel_op(ACT_WRITE, 0, -1, 0, 1'b1);
        voxel_op(ACT_WRITE, 0, CHUNK_TALL_DEF, 0, 1'b1);
        voxel_op(ACT_QUERY, 0, 0, 0, 1'b0);
        voxel_op(ACT_QUERY, 1, 1, 0, 1'b0);
        // A second slot with the same tag stays hidden until the first is unloaded.
        slot_op(ACT_LOAD, 3, 0, 0);
        voxel_op(ACT_WRITE, 0, 2, 0, 1'b1);
        slot_op(ACT_UNLOAD, 0, 0, 0);
        voxel_op(ACT_QUERY, 0, 1, 0, 1'b0);
        slot_op(ACT_LOAD, 0, 0, 0);
        voxel_op(ACT_QUERY, 0, 1, 0, 1'b0);
        slot_op(ACT_LOAD, 15, 2047, 2047);
        voxel_op(ACT_WRITE, 32767, CHUNK_TALL_DEF - 1, 32767, 1'b1);
        voxel_op(ACT_QUERY, 32767, CHUNK_TALL_DEF - 2, 32767, 1'b0);
        slot_op(ACT_LOAD, 14, -2048, -2048);
        voxel_op(ACT_WRITE, -32768, 0, -32768, 1'b1);
        voxel_op(ACT_QUERY, -32767, 0, -32768, 1'b0);
        slot_op(ACT_LOAD, 1, 5, -5);
        voxel_op(ACT_QUERY, 0, 63, 0, 1'b0);
        voxel_op(ACT_WRITE, 0, 0, 0, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == HOLD_AT)
                hold_now = 1'b1;
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            if ($urandom_range(0, 99) == 0)
                tx_calm = !tx_calm;
            random_item();
        end
        s_axis_tvalid <= 1'b0;

        while (world.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d loads, %0d unloads, %0d writes (%0d refused), %0d queries (%0d hidden).",
                 world.n_load, world.n_unload, world.n_write, world.n_write_refused,
                 world.n_query, world.n_hidden);
        $display("Checked %0d results with %0d mismatches.", world.n_checked, world.n_errors);
        if (world.n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
sv/vfv_pkg.sv
sv/voxel_face_visibility_unit.sv
sim/tb.sv
